// ===== sv/srdz_pkg.sv =====
// shared types, constants and per-stage datapath function for the radial dead zone unit
`timescale 1ns / 1ps

package srdz_pkg;

  localparam logic [15:0] DEAD_ZONE_RESET = 16'd8000;
  localparam logic [15:0] MAX_VALUE_RESET = 16'd30000;
  localparam logic [14:0] FULL_SCALE = 15'd16384;

  localparam logic [7:0] REG_DEAD_ZONE = 8'd0;
  localparam logic [7:0] REG_MAX_VALUE = 8'd1;

  // stage map
  localparam int SQ_STAGE    = 1;
  localparam int SUM_STAGE   = 2;
  localparam int SQRT_FIRST  = 3;
  localparam int SQRT_LAST   = 18;
  localparam int PREP_STAGE  = 19;
  localparam int FDIV_FIRST  = 20;
  localparam int FDIV_LAST   = 33;
  localparam int PROD_STAGE  = 34;
  localparam int CDIV_FIRST  = 35;
  localparam int CDIV_LAST   = 49;
  localparam int OUT_STAGE   = 50;
  localparam int NUM_STAGES  = 51;

  typedef struct packed {
    logic [15:0] dead_zone;
    logic [15:0] span;
    logic        degen;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [30:0]        sqx;
    logic [30:0]        sqy;
    logic [31:0]        rad;
    logic [15:0]        root;
    logic [19:0]        srem;
    logic               zero;
    logic               sat;
    logic [16:0]        drem;
    logic [13:0]        dq;
    logic [29:0]        px;
    logic [29:0]        py;
    logic [16:0]        rx;
    logic [16:0]        ry;
    logic [14:0]        qx;
    logic [14:0]        qy;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
  } stage_t;

  function automatic stage_t stage_fn(input logic [5:0] k, input stage_t p, input cfg_t c);
    stage_t             n;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic [19:0]        rem;
    logic [19:0]        trial;
    logic [15:0]        dd;
    logic [16:0]        t;
    logic [14:0]        f;
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic [16:0]        tx;
    logic [16:0]        ty;
    n = p;
    xs = 32'(p.x);
    ys = 32'(p.y);
    if (k == 6'(SQ_STAGE)) begin
      n.sqx = 31'(xs * xs);
      n.sqy = 31'(ys * ys);
    end else if (k == 6'(SUM_STAGE)) begin
      n.rad = 32'(p.sqx) + 32'(p.sqy);
      n.root = '0;
      n.srem = '0;
    end else if (k >= 6'(SQRT_FIRST) && k <= 6'(SQRT_LAST)) begin
      // one root bit per stage
      rem = {p.srem[17:0], p.rad[31:30]};
      trial = {2'b00, p.root, 2'b01};
      n.rad = {p.rad[29:0], 2'b00};
      if (rem >= trial) begin
        n.srem = rem - trial;
        n.root = {p.root[14:0], 1'b1};
      end else begin
        n.srem = rem;
        n.root = {p.root[14:0], 1'b0};
      end
    end else if (k == 6'(PREP_STAGE)) begin
      dd = p.root - c.dead_zone;
      n.zero = (p.root < c.dead_zone) || (p.root == 16'd0);
      n.sat = c.degen || (dd >= c.span);
      n.drem = {1'b0, dd};
      n.dq = '0;
    end else if (k >= 6'(FDIV_FIRST) && k <= 6'(FDIV_LAST)) begin
      t = {p.drem[15:0], 1'b0};
      if (t >= {1'b0, c.span}) begin
        n.drem = t - {1'b0, c.span};
        n.dq = {p.dq[12:0], 1'b1};
      end else begin
        n.drem = t;
        n.dq = {p.dq[12:0], 1'b0};
      end
    end else if (k == 6'(PROD_STAGE)) begin
      f = p.sat ? FULL_SCALE : {1'b0, p.dq};
      ax = p.x[15] ? 16'(-p.x) : 16'(p.x);
      ay = p.y[15] ? 16'(-p.y) : 16'(p.y);
      n.px = 30'(32'(ax) * 32'(f));
      n.py = 30'(32'(ay) * 32'(f));
      // quotient stays below 2^15, so the top bits are already below len
      n.rx = {2'b00, n.px[29:15]};
      n.ry = {2'b00, n.py[29:15]};
      n.px = {n.px[14:0], 15'd0};
      n.py = {n.py[14:0], 15'd0};
      n.qx = '0;
      n.qy = '0;
    end else if (k >= 6'(CDIV_FIRST) && k <= 6'(CDIV_LAST)) begin
      tx = {p.rx[15:0], p.px[29]};
      ty = {p.ry[15:0], p.py[29]};
      n.px = {p.px[28:0], 1'b0};
      n.py = {p.py[28:0], 1'b0};
      if (tx >= {1'b0, p.root}) begin
        n.rx = tx - {1'b0, p.root};
        n.qx = {p.qx[13:0], 1'b1};
      end else begin
        n.rx = tx;
        n.qx = {p.qx[13:0], 1'b0};
      end
      if (ty >= {1'b0, p.root}) begin
        n.ry = ty - {1'b0, p.root};
        n.qy = {p.qy[13:0], 1'b1};
      end else begin
        n.ry = ty;
        n.qy = {p.qy[13:0], 1'b0};
      end
    end else if (k == 6'(OUT_STAGE)) begin
      if (p.zero) begin
        n.ox = '0;
        n.oy = '0;
      end else begin
        n.ox = p.x[15] ? -signed'({1'b0, p.qx}) : signed'({1'b0, p.qx});
        n.oy = p.y[15] ? -signed'({1'b0, p.qy}) : signed'({1'b0, p.qy});
      end
    end
    return n;
  endfunction

endpackage

// ===== sv/stick_radial_dead_zone_unit.sv =====
// top level of the radial dead zone unit: config registers and stream ports
`timescale 1ns / 1ps

// Radial dead zone scaling for one analog stick. Each input item carries a
// signed (x, y) sample; the unit forms len = floor(sqrt(x*x + y*y)), forces
// the output to zero below dead_zone, and otherwise scales both components
// by f / len where f = min((len - dead_zone) * 16384 / (max_value -
// dead_zone), 16384) in Q1.14 (f is full scale when max_value <= dead_zone).
// Results are truncated toward zero. One item enters per clock unless a
// stalled output backs up the 51-stage pipeline: a 16-stage digit-by-digit
// square root, a 14-stage fraction divider and a 15-stage component divider
// (both components divided side by side). Every stage is elastic, so a
// stalled output lets earlier stages close up bubbles and keep taking items.
// Config writes are always accepted (cfg_ready is tied high) and must land
// only while the unit holds no item.

module stick_radial_dead_zone_unit (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] stick_x, [31:16] stick_y
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] out_x, [31:16] out_y
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import srdz_pkg::*;

  logic [15:0]        dead_zone;
  logic [15:0]        max_value;
  cfg_t               cfg;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;

  assign cfg_ready = 1'b1;

  // unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DEAD_ZONE_RESET;
      max_value <= MAX_VALUE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEAD_ZONE: dead_zone <= cfg_data;
        REG_MAX_VALUE: max_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // span only matters when max_value is above dead_zone
  assign cfg.dead_zone = dead_zone;
  assign cfg.span      = max_value - dead_zone;
  assign cfg.degen     = (max_value <= dead_zone);

  srdz_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_x      (s_axis_tdata[15:0]),
    .in_y      (s_axis_tdata[31:16]),
    .cfg       (cfg),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (out_x),
    .out_y     (out_y)
  );

  assign m_axis_tdata = {out_y, out_x};

endmodule

// ===== sv/srdz_pipe.sv =====
// elastic datapath pipeline: squares, root, fraction divide, component divide
`timescale 1ns / 1ps

module srdz_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  srdz_pkg::cfg_t     cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y
);
  import srdz_pkg::*;

  stage_t                st   [NUM_STAGES];
  stage_t                st_next [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   rdy;
  stage_t                head;

  always_comb begin
    head = '0;
    head.x = in_x;
    head.y = in_y;
  end

  // a stage loads when it is empty or its successor moves
  always_comb begin
    rdy[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_comb begin
    st_next[0] = head;
    for (int i = 1; i < NUM_STAGES; i++) begin
      st_next[i] = stage_fn(6'(i), st[i-1], cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (rdy[i]) begin
        st[i] <= st_next[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NUM_STAGES-1];
  assign out_x     = st[NUM_STAGES-1].ox;
  assign out_y     = st[NUM_STAGES-1].oy;

endmodule

// ===== tb/tb_top.sv =====
// testbench for the radial dead zone unit: stream stimulus, config phases, scoreboard
`timescale 1ns / 1ps

module tb_top;
  import srdz_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int errors = 0;
  bit sending_done = 1'b0;

  always #6 clk = ~clk;

  stick_radial_dead_zone_unit u_top (.*);

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // scaled-sample scoreboard; holds its own copy of the two registers
  class scaled_sample_board;
    logic [15:0] dz = DEAD_ZONE_RESET;
    logic [15:0] mx = MAX_VALUE_RESET;
    logic [31:0] pending[$];
    int          seen_count;

    function void write_reg(logic [7:0] idx, logic [15:0] val);
      if (idx == REG_DEAD_ZONE) dz = val;
      else if (idx == REG_MAX_VALUE) mx = val;
    endfunction

    // integer floor square root, bit by bit
    function longint isqrt(longint v);
      longint r;
      r = 0;
      for (int b = 15; b >= 0; b--)
        if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) r += 64'd1 << b;
      return r;
    endfunction

    function logic [31:0] scale(logic signed [15:0] x, logic signed [15:0] y);
      longint len, f, ox, oy;
      len = isqrt(longint'(x) * x + longint'(y) * y);
      ox = 0;
      oy = 0;
      if (len >= dz && len != 0) begin
        if (mx <= dz) f = 16384;
        else begin
          f = ((len - dz) * 16384) / (mx - dz);
          if (f > 16384) f = 16384;
        end
        // longint division truncates toward zero
        ox = (longint'(x) * f) / len;
        oy = (longint'(y) * f) / len;
      end
      return {oy[15:0], ox[15:0]};
    endfunction

    function void note_input(logic [31:0] d);
      pending.push_back(scale(d[15:0], d[31:16]));
    endfunction

    task check_result(logic [31:0] d);
      logic [31:0] e;
      seen_count++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e[15:0])
        report($sformatf("out_x got %0d want %0d", $signed(d[15:0]), $signed(e[15:0])));
      if (d[31:16] !== e[31:16])
        report($sformatf("out_y got %0d want %0d", $signed(d[31:16]), $signed(e[31:16])));
    endtask
  endclass

  scaled_sample_board board = new();

  // sample both handshakes at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) board.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end
  end

  // result side: random stalls, with calm stretches
  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic send_sample(input logic [15:0] x, input logic [15:0] y, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random sample: mostly near the interesting lengths, some extremes
  task automatic random_sample(input bit calm);
    logic [15:0] x, y;
    case ($urandom_range(0, 5))
      0: begin x = 16'($urandom); y = 16'($urandom); end
      1: begin
        x = 16'($urandom_range(0, 400) - 200);
        y = 16'($urandom_range(0, 400) - 200);
      end
      2: begin x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff; y = 16'($urandom); end
      default: begin
        x = 16'($urandom_range(0, 24000) - 12000);
        y = 16'($urandom_range(0, 24000) - 12000);
      end
    endcase
    send_sample(x, y, calm);
  endtask

  localparam int PHASES = 6;

  initial begin
    logic [15:0] dzs[PHASES] = '{16'd8000, 16'd0, 16'd65535, 16'd100, 16'd20000, 16'd3000};
    logic [15:0] mxs[PHASES] = '{16'd30000, 16'd65535, 16'd0, 16'd101, 16'd20000, 16'd46341};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, extremes and special cases
    send_sample(16'h0000, 16'h0000, 1);  // zero length
    send_sample(16'h7fff, 16'h0000, 1);
    send_sample(16'h8000, 16'h0000, 1);
    send_sample(16'h0000, 16'h8000, 1);
    send_sample(16'h8000, 16'h8000, 1);
    send_sample(16'h7fff, 16'h7fff, 1);
    send_sample(16'd7999, 16'h0000, 0);  // just inside dead zone
    send_sample(16'd8000, 16'h0000, 0);  // on the edge
    send_sample(16'hffff, 16'hffff, 0);
    send_sample(16'd20000, -16'sd20000, 0);
    drain();
    write_reg(REG_DEAD_ZONE, 16'd0);
    write_reg(8'd7, 16'hffff);  // unknown index is ignored
    send_sample(16'h0000, 16'h0000, 1);  // zero length with no dead zone
    send_sample(16'h0001, 16'hffff, 1);
    send_sample(16'h8000, 16'h7fff, 1);
    drain();
    write_reg(REG_MAX_VALUE, 16'd0);  // degenerate range
    send_sample(16'h0003, 16'h0004, 1);
    send_sample(16'h8000, 16'h0001, 1);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_DEAD_ZONE, dzs[ph]);
      write_reg(REG_MAX_VALUE, mxs[ph]);
      for (int i = 0; i < 225; i++) random_sample(i % 60 < 15);
      // pause until the pipeline is empty, then resume
      if (ph == 2) drain();
    end
    drain();
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    $display("covered %0d results over %0d register settings, incl. degenerate range",
             board.seen_count, PHASES + 2);
    $display("and zero length, with random stalls on both streams");
    if (errors == 0 && board.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== stick_radial_dead_zone_unit.f =====
sv/srdz_pkg.sv
sv/srdz_pipe.sv
sv/stick_radial_dead_zone_unit.sv
tb/tb_top.sv
